// ----- rtl/rhht_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the robin hood hash table unit
// used by the controller, the datapath and the top level
package rhht_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 11;
  localparam int LIM_W   = 10;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd921;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_KEY0 = 2'd3;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_START = 11'b00000000100,
    S_FRD   = 11'b00000001000,
    S_FCHK  = 11'b00000010000,
    S_IRD   = 11'b00000100000,
    S_ICHK  = 11'b00001000000,
    S_ERD   = 11'b00010000000,
    S_ECHK  = 11'b00100000000,
    S_EZERO = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       clr;
    logic       accept;
    logic       wr_carry;
    logic       swap;
    logic       step;
    logic       er_start;
    logic       wr_shift;
    logic       wr_zero;
    logic       fin;
    logic [1:0] fin_status;
    logic       fin_found;
    logic       fin_hit;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       push;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic [1:0] cmd;
    logic       key_zero;
    logic       full;
    logic       cur_zero;
    logic       cur_match;
    logic       dist_gt;
    logic       d_lt;
    logic       d_zero;
    logic       n_last;
    logic       out_free;
  } ctrl_sts_t;

endpackage

// ----- rtl/robin_hood_hash_table_unit.sv -----
`timescale 1ns / 1ps
// robin hood hash table unit: open addressing with backward-shift remove
// instantiates rhht_ctrl and rhht_dp, depends on rhht_pkg
//
// input stream s_*: s_tuser carries the command (insert, lookup, remove),
// s_tdata the key and the value. output stream m_*: one result per
// transaction, status and found flag in m_tuser, value and entry count in
// m_tdata. load_limit_we/load_limit_wdata write the entry count at which
// inserts are refused as full; write it only while the unit is idle.
// after reset the key store is cleared one slot a cycle, with s_tready low.
// an operation probes slot by slot, one registered memory read and one
// compare per slot probed, and on a remove per slot examined behind the
// removed key; the next item is accepted once the result has gone to the
// output register. a stalled receiver holds the result in m_tdata; one
// further result may then wait inside, with s_tready low until it moves
// to the output register.
module robin_hood_hash_table_unit import rhht_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_limit_we,
  input  logic [LIM_W-1:0] load_limit_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       s_tuser,   // cmd
  input  logic [63:0]      s_tdata,   // key [31:0], data_value [63:32]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [2:0]       m_tuser,   // status [1:0], found [2]
  output logic [47:0]      m_tdata    // result_value [31:0], entry_count [42:32]
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  rhht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rhht_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .load_limit_we    (load_limit_we),
    .load_limit_wdata (load_limit_wdata),
    .in_cmd           (s_tuser),
    .in_key           (s_tdata[31:0]),
    .in_value         (s_tdata[63:32]),
    .cmd              (cmd),
    .sts              (sts),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tuser          (m_tuser),
    .m_tdata          (m_tdata)
  );

endmodule

// ----- rtl/rhht_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for clear, insert, lookup and backward-shift remove
// depends on rhht_pkg
module rhht_ctrl import rhht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.cmd == CMD_NOP) begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_OK;
          state_next = S_RESP;
        end else if (sts.key_zero) begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_KEY0;
          state_next = S_RESP;
        end else if (sts.cmd == CMD_INSERT) begin
          if (sts.full) begin
            cmd.fin = 1'b1;
            cmd.fin_status = ST_FULL;
            state_next = S_RESP;
          end else begin
            state_next = S_IRD;
          end
        end else begin
          state_next = S_FRD;
        end
      end
      S_FRD: state_next = S_FCHK;
      S_FCHK: begin
        if (sts.cur_match) begin
          if (sts.cmd == CMD_LOOKUP) begin
            cmd.fin = 1'b1;
            cmd.fin_status = ST_OK;
            cmd.fin_found = 1'b1;
            cmd.fin_hit = 1'b1;
            state_next = S_RESP;
          end else begin
            cmd.er_start = 1'b1;
            state_next = S_ERD;
          end
        end else if (sts.cur_zero || sts.dist_gt || sts.n_last) begin
          cmd.fin = 1'b1;
          cmd.fin_status = ST_MISS;
          state_next = S_RESP;
        end else begin
          cmd.step = 1'b1;
          state_next = S_FRD;
        end
      end
      S_IRD: state_next = S_ICHK;
      S_ICHK: begin
        if (sts.cur_zero) begin
          cmd.wr_carry = 1'b1;
          cmd.fin = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.cnt_inc = 1'b1;
          state_next = S_RESP;
        end else begin
          // displace a resident that sits nearer its home
          if (sts.d_lt) begin
            cmd.wr_carry = 1'b1;
            cmd.swap = 1'b1;
          end
          if (sts.n_last) begin
            cmd.fin = 1'b1;
            cmd.fin_status = ST_OK;
            cmd.cnt_inc = 1'b1;
            state_next = S_RESP;
          end else begin
            cmd.step = 1'b1;
            state_next = S_IRD;
          end
        end
      end
      S_ERD: state_next = S_ECHK;
      S_ECHK: begin
        if (sts.cur_zero || sts.d_zero) begin
          cmd.wr_zero = 1'b1;
          cmd.fin = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.fin_found = 1'b1;
          cmd.cnt_dec = 1'b1;
          state_next = S_RESP;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.step = 1'b1;
          state_next = sts.n_last ? S_EZERO : S_ERD;
        end
      end
      S_EZERO: begin
        cmd.wr_zero = 1'b1;
        cmd.fin = 1'b1;
        cmd.fin_status = ST_OK;
        cmd.fin_found = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/rhht_dp.sv -----
`timescale 1ns / 1ps
// key and value stores, probe registers, entry count and output register
// depends on rhht_pkg
module rhht_dp import rhht_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int AW = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_limit_we,
  input  logic [LIM_W-1:0]   load_limit_wdata,
  input  logic [1:0]         in_cmd,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VAL_W-1:0]   in_value,
  input  ctrl_cmd_t          cmd,
  output ctrl_sts_t          sts,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [2:0]         m_tuser,
  output logic [47:0]        m_tdata
);

  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;

  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] ck;
  logic [VAL_W-1:0] cv;
  logic [VAL_W-1:0] dv;
  logic [AW-1:0]    slot, pdist, n, clr_cnt, d;
  logic [CNT_W-1:0] count;
  logic [LIM_W-1:0] limit;
  logic [1:0]       res_status;
  logic             res_found;
  logic [VAL_W-1:0] res_value;

  logic             key_we, val_we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] wkey;
  logic [VAL_W-1:0] wval;

  // distance of the resident from its home slot
  assign d = slot - rd_key[AW-1:0];

  always_comb begin
    key_we = cmd.clr | cmd.wr_carry | cmd.wr_shift | cmd.wr_zero;
    val_we = cmd.wr_carry | cmd.wr_shift;
    waddr  = slot - AW'(1);
    wkey   = '0;
    wval   = cv;
    if (cmd.clr) begin
      waddr = clr_cnt;
    end else if (cmd.wr_carry) begin
      waddr = slot;
      wkey  = ck;
    end else if (cmd.wr_shift) begin
      wkey = rd_key;
      wval = rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[waddr] <= wkey;
    if (val_we) val_mem[waddr] <= wval;
    rd_key <= key_mem[slot];
    rd_val <= val_mem[slot];
  end

  always_comb begin
    sts.clr_last  = (clr_cnt == LAST);
    sts.cmd       = cmd_r;
    sts.key_zero  = (ck == '0);
    sts.full      = (count >= CNT_W'(limit)) || (32'(count) >= CAPACITY);
    sts.cur_zero  = (rd_key == '0);
    sts.cur_match = (rd_key == ck);
    sts.dist_gt   = (pdist > d);
    sts.d_lt      = (d < pdist);
    sts.d_zero    = (d == '0);
    sts.n_last    = (n == LAST);
    sts.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_cmd;
      ck    <= in_key;
      cv    <= in_value;
      dv    <= in_value;
      slot  <= in_key[AW-1:0];
      pdist <= '0;
      n     <= '0;
    end else if (cmd.er_start) begin
      slot <= slot + AW'(1);
      n    <= AW'(1);
    end else if (cmd.step) begin
      slot  <= slot + AW'(1);
      n     <= n + AW'(1);
      pdist <= (cmd.swap ? d : pdist) + AW'(1);
    end
    if (cmd.swap) begin
      ck <= rd_key;
      cv <= rd_val;
    end
    if (cmd.fin) begin
      res_status <= cmd.fin_status;
      res_found  <= cmd.fin_found;
      res_value  <= cmd.fin_hit ? rd_val : dv;
    end
    if (cmd.push) begin
      m_tuser <= {res_found, res_status};
      m_tdata <= {5'd0, count, res_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      count    <= '0;
      limit    <= LIMIT_RESET;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.clr) clr_cnt <= clr_cnt + AW'(1);
      if (load_limit_we) limit <= load_limit_wdata;
      if (cmd.cnt_inc) count <= count + CNT_W'(1);
      else if (cmd.cnt_dec && count != '0) count <= count - CNT_W'(1);
      if (cmd.push) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY) else $error("entry count above capacity");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) || count == $past(count) + CNT_W'(1) ||
         count == $past(count) - CNT_W'(1))) else $error("entry count jumped");
  a_no_key0_store: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_carry |-> ck != '0) else $error("key zero written to store");
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!m_tvalid || m_tready)) else $error("result overwritten");
`endif

endmodule

// ----- sim/robin_hood_hash_table_unit_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for robin_hood_hash_table_unit
// needs rhht_pkg and the unit's rtl; no external files
module robin_hood_hash_table_unit_tb;
  import rhht_pkg::*;

  localparam int SLOTS = 1024;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic load_limit_we = 1'b0;
  logic [LIM_W-1:0] load_limit_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [1:0] s_tuser = CMD_NOP;     // cmd
  logic [63:0] s_tdata = '0;         // key [31:0], data_value [63:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [2:0] m_tuser;               // status [1:0], found [2]
  logic [47:0] m_tdata;              // result_value [31:0], entry_count [42:32]

  robin_hood_hash_table_unit dut (
    .clk(clk), .rst(rst),
    .load_limit_we(load_limit_we), .load_limit_wdata(load_limit_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value;
    logic [10:0] count;
  } answer_t;

  // shadow table
  logic [31:0] shadow_keys [SLOTS];
  logic [31:0] shadow_vals [SLOTS];
  int unsigned shadow_total;
  logic [LIM_W-1:0] shadow_limit;

  answer_t answers_due[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [31:0] used_keys[$];

  function automatic int unsigned home_dist(int unsigned slot, logic [31:0] k);
    return (slot + SLOTS - (k % SLOTS)) % SLOTS;
  endfunction

  function automatic bit locate(logic [31:0] k, output int unsigned where);
    int unsigned slot;
    slot = k % SLOTS;
    where = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (shadow_keys[slot] == k) begin
        where = slot;
        return 1'b1;
      end
      if (shadow_keys[slot] == 0 || n > home_dist(slot, shadow_keys[slot])) return 1'b0;
      slot = (slot + 1) % SLOTS;
    end
    return 1'b0;
  endfunction

  function automatic answer_t table_op(logic [1:0] cmd, logic [31:0] k, logic [31:0] dv);
    answer_t a;
    int unsigned slot, pdist, d, hole, off;
    logic [31:0] ck, cv, tk, tv;
    a = '{status: ST_OK, found: 1'b0, value: dv, count: '0};
    if (cmd == CMD_NOP) begin
    end else if (k == 0) begin
      a.status = ST_KEY0;
    end else if (cmd == CMD_INSERT) begin
      if (shadow_total >= shadow_limit || shadow_total >= SLOTS) begin
        a.status = ST_FULL;
      end else begin
        slot = k % SLOTS;
        pdist = 0;
        ck = k;
        cv = dv;
        for (int n = 0; n < SLOTS; n++) begin
          if (shadow_keys[slot] == 0) begin
            shadow_keys[slot] = ck;
            shadow_vals[slot] = cv;
            break;
          end
          d = home_dist(slot, shadow_keys[slot]);
          if (d < pdist) begin
            tk = shadow_keys[slot];
            tv = shadow_vals[slot];
            shadow_keys[slot] = ck;
            shadow_vals[slot] = cv;
            ck = tk;
            cv = tv;
            pdist = d;
          end
          slot = (slot + 1) % SLOTS;
          pdist++;
        end
        shadow_total++;
      end
    end else if (cmd == CMD_LOOKUP) begin
      if (locate(k, slot)) begin
        a.found = 1'b1;
        a.value = shadow_vals[slot];
      end else begin
        a.status = ST_MISS;
      end
    end else begin
      if (locate(k, hole)) begin
        a.found = 1'b1;
        for (off = 1; off < SLOTS; off++) begin
          tk = shadow_keys[(hole + off) % SLOTS];
          if (tk == 0 || home_dist((hole + off) % SLOTS, tk) == 0) break;
          shadow_keys[(hole + off - 1) % SLOTS] = tk;
          shadow_vals[(hole + off - 1) % SLOTS] = shadow_vals[(hole + off) % SLOTS];
        end
        shadow_keys[(hole + off - 1) % SLOTS] = 0;
        if (shadow_total > 0) shadow_total--;
      end else begin
        a.status = ST_MISS;
      end
    end
    a.count = shadow_total[10:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    errors++;
    $display("mismatch on result %0d: %s got %0h expected %0h", received, what, got, want);
  endtask

  // output side: random stall, compare on each transaction
  always @(posedge clk) begin
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        errors++;
        $display("unexpected result %0d", received);
      end else begin
        want = answers_due.pop_front();
        if (m_tuser[1:0] !== want.status)
          report_mismatch("status", 48'(m_tuser[1:0]), 48'(want.status));
        if (m_tuser[2] !== want.found)
          report_mismatch("found", 48'(m_tuser[2]), 48'(want.found));
        if (m_tdata[31:0] !== want.value)
          report_mismatch("value", 48'(m_tdata[31:0]), 48'(want.value));
        if (m_tdata[42:32] !== want.count)
          report_mismatch("count", 48'(m_tdata[42:32]), 48'(want.count));
      end
      received++;
    end
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("robin_hood_hash_table_unit_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, logic [31:0] k, logic [31:0] dv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {dv, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    answers_due.push_back(table_op(cmd, k, dv));
    if (cmd == CMD_INSERT && k != 0) used_keys.push_back(k);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);   // let the output side settle before a register write
  endtask

  task automatic set_limit(logic [LIM_W-1:0] lim);
    load_limit_we <= 1'b1;
    load_limit_wdata <= lim;
    shadow_limit = lim;
    @(negedge clk);
    load_limit_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 45 && used_keys.size() != 0) return used_keys[$urandom_range(used_keys.size() - 1)];
    if (r < 85) return ($urandom_range(7) << 10) | $urandom_range(63) | 1; // cluster near few homes
    if (r < 88) return 32'h0;
    return $urandom;
  endfunction

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] k;
    logic [31:0] dv;
    bit          typed;
    answer_t     want;
  } stim_row_t;

  stim_row_t directed [21] = '{
    '{CMD_LOOKUP, 32'h1, 32'hDEAD_BEEF, 1, '{ST_MISS, 1'b0, 32'hDEAD_BEEF, 11'd0}},
    '{CMD_REMOVE, 32'h1, 32'h0, 1, '{ST_MISS, 1'b0, 32'h0, 11'd0}},
    '{CMD_INSERT, 32'h0, 32'h5, 1, '{ST_KEY0, 1'b0, 32'h5, 11'd0}},
    '{CMD_LOOKUP, 32'h0, 32'h6, 1, '{ST_KEY0, 1'b0, 32'h6, 11'd0}},
    '{CMD_REMOVE, 32'h0, 32'h7, 1, '{ST_KEY0, 1'b0, 32'h7, 11'd0}},
    '{CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{ST_OK, 1'b0, 32'hFFFF_FFFF, 11'd0}},
    '{CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '{ST_OK, 1'b0, 32'hFFFF_FFFF, 11'd1}},
    '{CMD_INSERT, 32'h0000_03FF, 32'h1111, 0, '0},
    '{CMD_INSERT, 32'h0000_0400, 32'h2222, 0, '0},
    '{CMD_INSERT, 32'h0000_0800, 32'h3333, 0, '0},
    '{CMD_INSERT, 32'h0000_0401, 32'h4444, 0, '0},
    '{CMD_INSERT, 32'h0000_0400, 32'h5555, 0, '0},
    '{CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0, '0},
    '{CMD_LOOKUP, 32'h0000_0400, 32'h0, 0, '0},
    '{CMD_LOOKUP, 32'h0000_0C00, 32'h9, 0, '0},
    '{CMD_REMOVE, 32'h0000_0400, 32'h0, 0, '0},
    '{CMD_LOOKUP, 32'h0000_0400, 32'h0, 0, '0},
    '{CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 0, '0},
    '{CMD_LOOKUP, 32'h0000_0401, 32'h0, 0, '0},
    '{CMD_REMOVE, 32'h0000_0800, 32'h0, 0, '0},
    '{CMD_LOOKUP, 32'h0000_0401, 32'h0, 0, '0}
  };

  int phase_pct [4][2] = '{'{0, 0}, '{82, 0}, '{0, 82}, '{12, 12}};
  logic [LIM_W-1:0] phase_limit [4] = '{10'd1023, 10'd1, 10'd40, 10'd921};

  initial begin
    answer_t got_ans;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    shadow_total = 0;
    shadow_limit = LIMIT_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].typed) begin
        got_ans = table_op(directed[i].cmd, directed[i].k, directed[i].dv);
        if (got_ans !== directed[i].want)
          report_mismatch("predictor", 48'(got_ans), 48'(directed[i].want));
        // typed rows are checked against their fixed answer
        answers_due.push_back(directed[i].want);
        s_tvalid <= 1'b1;
        s_tuser <= directed[i].cmd;
        s_tdata <= {directed[i].dv, directed[i].k};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (directed[i].cmd == CMD_INSERT && directed[i].k != 0)
          used_keys.push_back(directed[i].k);
        sent++;
        @(negedge clk);
      end else begin
        send_item(directed[i].cmd, directed[i].k, directed[i].dv);
      end
    end
    drain();

    for (int p = 0; p < 4; p++) begin
      set_limit(phase_limit[p]);
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int n = 0; n < 200; n++) begin
        if (n == 100) begin
          // hold off until the unit has answered everything
          s_tvalid <= 1'b0;
          @(negedge clk);
          while (answers_due.size() != 0) @(negedge clk);
        end
        send_item($urandom_range(99) < 50 ? CMD_INSERT :
                  ($urandom_range(99) < 60 ? CMD_LOOKUP :
                  ($urandom_range(99) < 90 ? CMD_REMOVE : CMD_NOP)),
                  pick_key(), $urandom);
      end
      drain();
    end

    $display("covered %0d operations over limits 1023, 1, 40 and 921, with idle and stall phases",
             sent);
    $display("results checked: %0d, entries left: %0d", received, shadow_total);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("robin_hood_hash_table_unit_tb: PASS");
    end else begin
      $display("robin_hood_hash_table_unit_tb: FAIL");
    end
    $finish;
  end
endmodule
